// ===== hdl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants shared by the positional list engine and its cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_APPEND = 3'd4,
    ACT_DROP   = 3'd5,
    ACT_CLEAR  = 3'd6,
    ACT_FIND   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // what each cell does with its entry this cycle
  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_WRITE  = 2'd1,
    CM_INSERT = 2'd2,
    CM_REMOVE = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t               mode;
    logic signed [DATA_W-1:0] val;
  } cell_ctl_t;

  typedef struct packed {
    action_t                  action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         count;
    status_t                  status;
  } out_result_t;

endpackage

// ===== hdl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, loads, shifts from either neighbor, and
// flags whether it is selected and whether it beats the threshold.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
  parameter int IDX = 0,
  parameter int WW  = 7
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [WW-1:0]            sel_pos,
  input  logic [WW-1:0]            fill,
  input  logic signed [DATA_W-1:0] left_in,
  input  logic signed [DATA_W-1:0] right_in,
  output logic signed [DATA_W-1:0] entry,
  output logic                     sel,
  output logic                     hit
);

  localparam logic [WW-1:0] MY_IDX = WW'(IDX);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic                     at_pos;
  logic                     above;

  assign at_pos = (MY_IDX == sel_pos);
  assign above  = (MY_IDX > sel_pos);

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      CM_HOLD: begin
        entry_nxt = entry_r;
      end
      CM_WRITE: begin
        if (at_pos) begin
          entry_nxt = ctl.val;
        end
      end
      CM_INSERT: begin
        if (at_pos) begin
          entry_nxt = ctl.val;
        end else if (above) begin
          entry_nxt = left_in;
        end
      end
      CM_REMOVE: begin
        if (at_pos || above) begin
          entry_nxt = right_in;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign sel   = at_pos;
  // only live entries take part in the search
  assign hit   = (MY_IDX < fill) && ($signed(entry_r) > $signed(ctl.val));

endmodule

// ===== hdl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values kept in a row of shifting cells with a fill
// count; read, write, insert, remove, append, drop, clear and find greater.
// ----------------------------------------------------------------------------
// flow: an accepted start loads the command and moves to the execute state, in which
//   the cell row shifts and the read / first-match reduction runs; the result and
//   out_valid are registered from it, and busy holds off a new command meanwhile
// reset: fill count and strobe cleared, cell entries keep their contents
// the receiver cannot stall: each result shows for exactly one cycle
module positional_list_engine import ple_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_result_t out_result
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t      state_r;
  in_item_t    cmd_r;
  logic [CW-1:0] fill_r;
  logic          out_valid_r;
  out_result_t   out_result_r;

  logic [CW-1:0] fill_nxt;
  out_result_t   res_nxt;
  cell_ctl_t     ctl;
  logic [WW-1:0] sel_pos;
  logic [WW-1:0] fill_w;
  logic [WW-1:0] pos_w;
  logic          full;
  logic          empty;

  logic signed [DATA_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0]         sels;
  logic [DEPTH-1:0]         hits;
  logic [DEPTH-1:0]         first_hit;
  logic signed [DATA_W-1:0] rd_data;
  logic [IW-1:0]            hit_idx;

  assign fill_w = WW'(fill_r);
  assign pos_w  = WW'(cmd_r.position);
  assign full   = (fill_r == CW'(DEPTH));
  assign empty  = (fill_r == '0);

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = ent[0];
    end else begin : g_mid
      assign left_v = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = ent[DEPTH-1];
    end else begin : g_inner
      assign right_v = ent[i+1];
    end
    ple_cell #(
      .IDX (i),
      .WW  (WW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel_pos  (sel_pos),
      .fill     (fill_w),
      .left_in  (left_v),
      .right_in (right_v),
      .entry    (ent[i]),
      .sel      (sels[i]),
      .hit      (hits[i])
    );
  end

  // read mux as and-or over the selected cell, first match by isolating low bit
  always_comb begin
    rd_data   = '0;
    hit_idx   = '0;
    first_hit = hits & (~hits + DEPTH'(1));
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | (ent[i] & {DATA_W{sels[i]}});
      if (first_hit[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  always_comb begin
    fill_nxt         = fill_r;
    ctl.mode         = CM_HOLD;
    ctl.val          = cmd_r.value;
    sel_pos          = pos_w;
    res_nxt.data     = '0;
    res_nxt.found_index = '0;
    res_nxt.status   = ST_OK;
    if (state_r == S_EXEC) begin
      unique case (cmd_r.action)
        ACT_READ: begin
          if (pos_w < fill_w) begin
            res_nxt.data = rd_data;
          end else begin
            res_nxt.status = ST_BAD_POS;
          end
        end
        ACT_WRITE: begin
          if (pos_w < fill_w) begin
            ctl.mode = CM_WRITE;
          end else begin
            res_nxt.status = ST_BAD_POS;
          end
        end
        ACT_INSERT: begin
          if (pos_w > fill_w) begin
            res_nxt.status = ST_BAD_POS;
          end else if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            ctl.mode = CM_INSERT;
            fill_nxt = fill_r + CW'(1);
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else if (pos_w >= fill_w) begin
            res_nxt.status = ST_BAD_POS;
          end else begin
            ctl.mode = CM_REMOVE;
            fill_nxt = fill_r - CW'(1);
          end
        end
        ACT_APPEND: begin
          if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            ctl.mode = CM_WRITE;
            sel_pos  = fill_w;
            fill_nxt = fill_r + CW'(1);
          end
        end
        ACT_DROP: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            fill_nxt = fill_r - CW'(1);
          end
        end
        ACT_CLEAR: begin
          fill_nxt = '0;
        end
        ACT_FIND: begin
          if (hits != '0) begin
            res_nxt.found_index = IDX_W'(hit_idx);
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
        end
        default: begin
          res_nxt.status = ST_OK;
        end
      endcase
    end
    res_nxt.count = CNT_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_item;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          fill_r       <= fill_nxt;
          out_result_r <= res_nxt;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_r == S_EXEC);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // every accepted transaction passes through the busy execute state and then yields its strobe
  a_start_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_valid)
    else $error("accepted transaction did not produce a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond capacity");

  a_index_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.status != ST_OK) |-> (out_result.found_index == '0))
    else $error("found index set on a failed transaction");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. A shadow copy of the
// list predicts every result from each accepted command. Directed edge cases
// come first, then a fill-to-capacity run, then random command streams with
// changing sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ple_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_result_t out_result;

  positional_list_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // shadow list, updated when a command is accepted
  logic signed [DATA_W-1:0] shadow_entries [LIST_DEPTH];
  int                       shadow_count;
  out_result_t              pending_results [$];
  int                       mismatch_count;
  int                       sender_idle_pct;

  localparam action_t ACTION_ORDER [8] = '{ACT_READ, ACT_WRITE, ACT_INSERT, ACT_REMOVE,
                                           ACT_APPEND, ACT_DROP, ACT_CLEAR, ACT_FIND};
  // weights per action in ACTION_ORDER: grow, shrink, mixed
  localparam int ACTION_WEIGHTS [3][8] = '{'{10, 10, 25,  5, 30,  3, 1, 16},
                                           '{10, 10,  5, 30,  5, 20, 2, 18},
                                           '{15, 15, 15, 15, 12,  8, 2, 18}};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic out_result_t apply_list_action(in_item_t it);
    out_result_t r;
    int          p;
    int          i;
    int          idx;
    r      = '0;
    r.status = ST_OK;
    p      = int'(it.position);
    idx    = 0;
    case (it.action)
      ACT_READ: begin
        if (p < shadow_count) r.data = shadow_entries[p];
        else r.status = ST_BAD_POS;
      end
      ACT_WRITE: begin
        if (p < shadow_count) shadow_entries[p] = it.value;
        else r.status = ST_BAD_POS;
      end
      ACT_INSERT: begin
        // position check wins over the full check
        if (p > shadow_count) begin
          r.status = ST_BAD_POS;
        end else if (shadow_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = it.value;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        // empty check wins over the position check
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = ST_BAD_POS;
        end else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      ACT_APPEND: begin
        if (shadow_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = it.value;
          shadow_count++;
        end
      end
      ACT_DROP: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      ACT_CLEAR: shadow_count = 0;
      default: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < shadow_count; i++) begin
          if ($signed(shadow_entries[i]) > $signed(it.value)) begin
            idx      = i;
            r.status = ST_OK;
            break;
          end
        end
      end
    endcase
    r.found_index = IDX_W'(idx);
    r.count       = CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic in_item_t make_item(action_t a, int p, logic signed [DATA_W-1:0] v);
    in_item_t it;
    it.action   = a;
    it.position = POS_W'(p);
    it.value    = v;
    return it;
  endfunction

  function automatic in_item_t random_item(int bias);
    in_item_t it;
    int       roll;
    int       acc;
    int       k;
    int       p;
    roll = $urandom_range(99);
    acc  = 0;
    it.action = ACT_FIND;
    for (k = 0; k < 8; k++) begin
      acc += ACTION_WEIGHTS[bias][k];
      if (roll < acc) begin
        it.action = ACTION_ORDER[k];
        break;
      end
    end
    roll = $urandom_range(99);
    if (roll < 70) p = $urandom_range(shadow_count);
    else if (roll < 80) p = shadow_count;
    else if (roll < 90) p = $urandom_range(127);
    else p = (shadow_count > 0) ? shadow_count - 1 : 0;
    it.position = POS_W'(p);
    roll = $urandom_range(99);
    if (it.action == ACT_FIND && shadow_count > 0 && roll < 50) begin
      // threshold on or just below a stored value probes the strict compare
      it.value = shadow_entries[$urandom_range(shadow_count - 1)] - $urandom_range(1);
    end else if (roll < 60) begin
      case ($urandom_range(3))
        0: it.value = 32'sh8000_0000;
        1: it.value = 32'sh7fff_ffff;
        2: it.value = '0;
        default: it.value = -1;
      endcase
    end else begin
      it.value = $urandom;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start   = 1'b1;
    in_item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(apply_list_action(it));
  endtask

  always @(posedge clk) begin
    out_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_result.data !== want.data) begin
          $error("data: expected %0d, got %0d", want.data, out_result.data);
          mismatch_count++;
        end
        if (out_result.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index,
                 out_result.found_index);
          mismatch_count++;
        end
        if (out_result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_result.count);
          mismatch_count++;
        end
        if (out_result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_result.status);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_and_bounds();
    send_item(make_item(ACT_READ,   0,   32'sd1));
    send_item(make_item(ACT_WRITE,  0,   32'sd2));
    send_item(make_item(ACT_REMOVE, 127, 32'sd0));
    send_item(make_item(ACT_DROP,   0,   32'sd0));
    send_item(make_item(ACT_FIND,   0,   32'sh8000_0000));
    send_item(make_item(ACT_INSERT, 1,   32'sd3));
  endtask

  task automatic test_edit_sequence();
    send_item(make_item(ACT_INSERT, 0,   32'sh8000_0000));
    send_item(make_item(ACT_APPEND, 99,  32'sh7fff_ffff));
    send_item(make_item(ACT_INSERT, 1,   32'sd0));
    send_item(make_item(ACT_INSERT, 3,   -32'sd1));
    send_item(make_item(ACT_READ,   0,   32'sd0));
    send_item(make_item(ACT_READ,   3,   32'sd0));
    send_item(make_item(ACT_READ,   4,   32'sd0));
    send_item(make_item(ACT_READ,   127, 32'sd0));
    send_item(make_item(ACT_FIND,   0,   -32'sd1));
    send_item(make_item(ACT_FIND,   0,   32'sh7fff_ffff));
    send_item(make_item(ACT_FIND,   0,   32'sh8000_0000));
    send_item(make_item(ACT_WRITE,  1,   32'sd5));
    send_item(make_item(ACT_REMOVE, 0,   32'sd0));
    send_item(make_item(ACT_REMOVE, 3,   32'sd0));
    send_item(make_item(ACT_REMOVE, 2,   32'sd0));
    send_item(make_item(ACT_DROP,   0,   32'sd0));
    // clear keeps the old entries but they must not be readable
    send_item(make_item(ACT_CLEAR,  0,   32'sd0));
    send_item(make_item(ACT_READ,   0,   32'sd0));
    send_item(make_item(ACT_APPEND, 0,   32'sd7));
    send_item(make_item(ACT_READ,   0,   32'sd0));
  endtask

  task automatic test_fill_to_full();
    send_item(make_item(ACT_CLEAR, 0, 32'sd0));
    while (shadow_count < LIST_DEPTH) begin
      if ($urandom_range(1)) send_item(make_item(ACT_APPEND, 0, $urandom));
      else send_item(make_item(ACT_INSERT, $urandom_range(shadow_count), $urandom));
    end
    send_item(make_item(ACT_INSERT, 0,          32'sd1));
    send_item(make_item(ACT_APPEND, 0,          32'sd1));
    send_item(make_item(ACT_INSERT, 65,         32'sd1));
    send_item(make_item(ACT_INSERT, LIST_DEPTH, 32'sd1));
    send_item(make_item(ACT_READ,   63,         32'sd0));
    send_item(make_item(ACT_READ,   LIST_DEPTH, 32'sd0));
    send_item(make_item(ACT_WRITE,  63,         32'sh7fff_ffff));
    send_item(make_item(ACT_FIND,   0,          32'sh7fff_ffff));
    send_item(make_item(ACT_FIND,   0,          32'sh7fff_fffe));
    send_item(make_item(ACT_REMOVE, 63,         32'sd0));
    send_item(make_item(ACT_INSERT, 63,         32'sd9));
    send_item(make_item(ACT_REMOVE, 0,          32'sd0));
    send_item(make_item(ACT_DROP,   0,          32'sd0));
  endtask

  task automatic test_random_mix(input int n_items, input int idle_pct);
    int bias;
    sender_idle_pct = idle_pct;
    bias = 2;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) bias = $urandom_range(2);
      send_item(random_item(bias));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    shadow_count    = 0;
    mismatch_count  = 0;
    sender_idle_pct = 17;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_bounds();
    test_edit_sequence();
    test_fill_to_full();
    test_random_mix(170, 17);
    test_random_mix(170, 74);
    test_random_mix(170, 0);

    @(negedge clk);
    start = 1'b0;
    for (int w = 0; w < 1000 && pending_results.size() > 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result transactions never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
verif/tb_top.sv
